/* sv/vdcrb_pkg.sv */
// Shared constants, codes and types for the video DAC / CRTC register block.
package vdcrb_pkg;

    localparam int PALETTE_BYTES      = 768;
    localparam int PAL_LANES          = 3;
    localparam int PAL_ROWS           = PALETTE_BYTES / PAL_LANES;
    localparam int PAL_ROW_W          = $clog2(PAL_ROWS);
    localparam int PAL_WORD_W         = 8 * PAL_LANES;
    localparam int REG_FILE_DEPTH_DEF = 16;
    localparam int REG_WORD_W         = 32;
    localparam int CLEAR_LEN          = 256;
    localparam int CLEAR_W            = $clog2(CLEAR_LEN);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] DEVICE_ID_RESET = 8'h3a;

    localparam logic [2:0] MODE_DAC_RD  = 3'd0;
    localparam logic [2:0] MODE_DAC_WR  = 3'd1;
    localparam logic [2:0] MODE_CRTC_RD = 3'd2;
    localparam logic [2:0] MODE_CRTC_WR = 3'd3;
    localparam logic [2:0] MODE_PIXEL   = 3'd4;

    localparam logic [2:0] DAC_OFF_INDEX  = 3'd0;
    localparam logic [2:0] DAC_OFF_DATA   = 3'd1;
    localparam logic [2:0] DAC_OFF_ID     = 3'd2;
    localparam logic [2:0] DAC_OFF_FILE_A = 3'd5;
    localparam logic [2:0] DAC_OFF_FILE_B = 3'd6;

    localparam logic [2:0] CRTC_OFF_LAST_BYTE = 3'd5;
    localparam logic [2:0] CRTC_OFF_INDEX     = 3'd6;
    localparam logic [2:0] CRTC_OFF_DATA      = 3'd7;
    localparam int         CRTC_BYTE_REGS     = 6;

    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    localparam int TIMING_HACT_START = 3;
    localparam int TIMING_HTOTAL     = 4;
    localparam int TIMING_VACT_START = 7;
    localparam int TIMING_VTOTAL     = 8;

    localparam logic [15:0] LOW_MASK  = 16'h00ff;
    localparam logic [15:0] HIGH_MASK = 16'hff00;

    localparam int MIN_SIZE   = 64;
    localparam int MAX_SIZE   = 2048;
    localparam int FALLBACK_W = 800;
    localparam int FALLBACK_H = 600;

    typedef struct packed {
        logic [15:0] hact_start;
        logic [15:0] htotal;
        logic [15:0] vact_start;
        logic [15:0] vtotal;
    } timing_shadow_t;

    typedef struct packed {
        logic [11:0] width;
        logic [11:0] height;
    } geom_t;

endpackage

/* sv/vdcrb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module vdcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/vdcrb_apb.sv */
// APB configuration port holding the RAMDAC identification register.
module vdcrb_apb (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vdcrb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vdcrb_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [vdcrb_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic [7:0]                        device_id
);
    import vdcrb_pkg::*;

    logic       id_sel;
    logic [7:0] device_id_reg;
    logic [7:0] device_id_next;

    assign id_sel = (paddr[CFG_ADDR_W-1] == 1'b0);
    assign pready = 1'b1;

    always_comb
    begin
        device_id_next = device_id_reg;
        if (psel && penable && pwrite && id_sel)
        begin
            device_id_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= DEVICE_ID_RESET;
        end
        else
        begin
            device_id_reg <= device_id_next;
        end
    end

    assign prdata    = id_sel ? {{(CFG_DATA_W-8){1'b0}}, device_id_reg} : '0;
    assign device_id = device_id_reg;

endmodule

/* sv/vdcrb_geom.sv */
// Active display size from the CRTC timing registers, with 800x600 fallback.
module vdcrb_geom (
    input  vdcrb_pkg::timing_shadow_t timing,
    output vdcrb_pkg::geom_t          geom
);
    import vdcrb_pkg::*;

    logic signed [18:0] diff_w;
    logic signed [18:0] w;
    logic signed [17:0] h;
    logic               in_range;

    assign diff_w = $signed({3'b000, timing.htotal}) - $signed({3'b000, timing.hact_start});
    assign w      = (diff_w <<< 1) + 19'sd2;
    assign h      = $signed({2'b00, timing.vtotal}) - $signed({2'b00, timing.vact_start})
                    + 18'sd1;

    assign in_range = (w >= MIN_SIZE) && (w <= MAX_SIZE) && (h >= MIN_SIZE) && (h <= MAX_SIZE);

    assign geom.width  = in_range ? w[11:0] : 12'(FALLBACK_W);
    assign geom.height = in_range ? h[11:0] : 12'(FALLBACK_H);

endmodule

/* sv/video_dac_crtc_register_block_unit.sv */
// Video DAC / CRTC register front end: one word in, one word out; each word is handled as a
// palette and register-file RAM read, then modify/write-back and output register load, and
// a new word is accepted only after that load, which waits while the output register is full.
// After reset a clearing pass zeroes both RAMs; in_ready stays low until it finishes.
module video_dac_crtc_register_block_unit #(
    parameter int REG_FILE_DEPTH = vdcrb_pkg::REG_FILE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vdcrb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vdcrb_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [vdcrb_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        mode,
    input  logic [2:0]                        offset,
    input  logic [7:0]                        write_data,
    input  logic [7:0]                        pixel_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        read_data,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic [11:0]                       active_width,
    output logic [11:0]                       active_height
);
    import vdcrb_pkg::*;

    localparam int               RIDX_W  = $clog2(REG_FILE_DEPTH);
    localparam int               QMAX    = 255 / REG_FILE_DEPTH;
    localparam int               QW      = $clog2(QMAX + 2);
    localparam int               MOD_SH  = 16;
    localparam logic [16:0]      MOD_MUL = 17'((1 << MOD_SH) / REG_FILE_DEPTH);
    localparam logic [9:0]       DEPTH10 = 10'(REG_FILE_DEPTH);
    localparam logic [CLEAR_W:0] DEPTHC  = (CLEAR_W+1)'(REG_FILE_DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    function automatic logic [RIDX_W-1:0] reduce_idx(input logic [7:0] v,
                                                     input logic [QW-1:0] q);
        logic [9:0] t;
        t = {2'b00, v} - 10'(q * REG_FILE_DEPTH);
        if (t >= DEPTH10)
        begin
            t = t - DEPTH10;
        end
        return t[RIDX_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [CLEAR_W-1:0]    clr_cnt_reg, clr_cnt_next;

    logic [2:0]            mode_reg, mode_next;
    logic [2:0]            offset_reg, offset_next;
    logic [7:0]            wdata_reg, wdata_next;

    logic [7:0]            dac_index_reg, dac_index_next;
    logic [QW-1:0]         dac_q_reg, dac_q_next;
    logic [7:0]            crtc_index_reg, crtc_index_next;
    logic [QW-1:0]         crtc_q_reg, crtc_q_next;
    logic                  crtc_high_reg, crtc_high_next;
    logic [PAL_ROW_W-1:0]  pal_row_reg, pal_row_next;
    logic [1:0]            pal_lane_reg, pal_lane_next;
    logic [7:0]            crtc_byte_reg [CRTC_BYTE_REGS];
    logic [7:0]            crtc_byte_next [CRTC_BYTE_REGS];
    timing_shadow_t        shadow_reg, shadow_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            read_data_reg, read_data_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [7:0]            blue_reg, blue_next;
    logic [11:0]           width_reg, width_next;
    logic [11:0]           height_reg, height_next;

    logic                  pal_we, pal_re;
    logic [PAL_ROW_W-1:0]  pal_waddr, pal_raddr;
    logic [PAL_WORD_W-1:0] pal_wdata, pal_rdata;
    logic                  reg_we, reg_re;
    logic [RIDX_W-1:0]     reg_waddr, reg_raddr;
    logic [REG_WORD_W-1:0] reg_wdata, reg_rdata;

    logic [RIDX_W-1:0]     dac_ridx, crtc_ridx;
    logic [7:0]            q_src;
    logic [24:0]           q_prod;
    logic [QW-1:0]         q_calc;
    logic [7:0]            device_id;
    logic                  accept, finish, is_wr;
    logic [7:0]            pal_byte;
    logic [15:0]           tv_old, tv_new;
    geom_t                 geom;

    vdcrb_apb u_apb (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .device_id (device_id)
    );

    vdcrb_ram #(
        .WIDTH (PAL_WORD_W),
        .DEPTH (PAL_ROWS)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    vdcrb_ram #(
        .WIDTH (REG_WORD_W),
        .DEPTH (REG_FILE_DEPTH)
    ) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (reg_re),
        .raddr (reg_raddr),
        .rdata (reg_rdata)
    );

    vdcrb_geom u_geom (
        .timing (shadow_next),
        .geom   (geom)
    );

    assign dac_ridx  = reduce_idx(dac_index_reg, dac_q_reg);
    assign crtc_ridx = reduce_idx(crtc_index_reg, crtc_q_reg);

    // quotient of the new index by the file depth, via reciprocal multiply
    assign q_src  = (mode_reg == MODE_CRTC_WR && offset_reg == CRTC_OFF_DATA)
                    ? crtc_index_reg + 8'd1 : wdata_reg;
    assign q_prod = q_src * MOD_MUL;
    assign q_calc = q_prod[MOD_SH +: QW];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign is_wr    = (mode_reg == MODE_DAC_WR) || (mode_reg == MODE_CRTC_WR);
    assign tv_old   = reg_rdata[15:0];

    always_comb
    begin
        case (pal_lane_reg)
            LANE_RED:   pal_byte = pal_rdata[23:16];
            LANE_GREEN: pal_byte = pal_rdata[15:8];
            default:    pal_byte = pal_rdata[7:0];
        endcase
    end

    // read issue
    always_comb
    begin
        pal_re    = accept;
        reg_re    = accept;
        pal_raddr = (mode == MODE_PIXEL) ? pixel_index : pal_row_reg;
        reg_raddr = (mode == MODE_CRTC_RD || mode == MODE_CRTC_WR) ? crtc_ridx : dac_ridx;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mode_next       = mode_reg;
        offset_next     = offset_reg;
        wdata_next      = wdata_reg;
        dac_index_next  = dac_index_reg;
        dac_q_next      = dac_q_reg;
        crtc_index_next = crtc_index_reg;
        crtc_q_next     = crtc_q_reg;
        crtc_high_next  = crtc_high_reg;
        pal_row_next    = pal_row_reg;
        pal_lane_next   = pal_lane_reg;
        crtc_byte_next  = crtc_byte_reg;
        shadow_next     = shadow_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_data_next  = read_data_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        width_next      = width_reg;
        height_next     = height_reg;

        pal_we    = 1'b0;
        pal_waddr = pal_row_reg;
        pal_wdata = pal_rdata;
        reg_we    = 1'b0;
        reg_waddr = (mode_reg == MODE_CRTC_RD || mode_reg == MODE_CRTC_WR) ? crtc_ridx : dac_ridx;
        reg_wdata = reg_rdata;
        tv_new    = tv_old;

        case (state_reg)
            ST_CLEAR:
            begin
                pal_we    = 1'b1;
                pal_waddr = clr_cnt_reg[PAL_ROW_W-1:0];
                pal_wdata = '0;
                reg_we    = ({1'b0, clr_cnt_reg} < DEPTHC);
                reg_waddr = clr_cnt_reg[RIDX_W-1:0];
                reg_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLEAR_W'(CLEAR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = mode;
                    offset_next = offset;
                    wdata_next  = write_data;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    read_data_next = '0;
                    red_next       = '0;
                    green_next     = '0;
                    blue_next      = '0;

                    case (mode_reg)
                        MODE_DAC_RD, MODE_DAC_WR:
                        begin
                            case (offset_reg)
                                DAC_OFF_INDEX:
                                begin
                                    if (is_wr)
                                    begin
                                        dac_index_next = wdata_reg;
                                        dac_q_next     = q_calc;
                                        pal_row_next   = wdata_reg;
                                        pal_lane_next  = LANE_RED;
                                    end
                                    else
                                    begin
                                        read_data_next = dac_index_reg;
                                    end
                                end
                                DAC_OFF_DATA:
                                begin
                                    if (is_wr)
                                    begin
                                        pal_we = 1'b1;
                                        case (pal_lane_reg)
                                            LANE_RED:
                                                pal_wdata = {wdata_reg, pal_rdata[15:0]};
                                            LANE_GREEN:
                                                pal_wdata = {pal_rdata[23:16], wdata_reg,
                                                             pal_rdata[7:0]};
                                            default:
                                                pal_wdata = {pal_rdata[23:8], wdata_reg};
                                        endcase
                                    end
                                    else
                                    begin
                                        read_data_next = pal_byte;
                                    end
                                    if (pal_lane_reg == LANE_BLUE)
                                    begin
                                        pal_lane_next = LANE_RED;
                                        pal_row_next  = pal_row_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        pal_lane_next = pal_lane_reg + 2'd1;
                                    end
                                end
                                DAC_OFF_ID:
                                begin
                                    if (!is_wr)
                                    begin
                                        read_data_next = device_id;
                                    end
                                end
                                DAC_OFF_FILE_A:
                                begin
                                    if (is_wr)
                                    begin
                                        reg_we    = 1'b1;
                                        reg_wdata = {wdata_reg, reg_rdata[23:0]};
                                    end
                                    else
                                    begin
                                        read_data_next = reg_rdata[31:24];
                                    end
                                end
                                DAC_OFF_FILE_B:
                                begin
                                    if (is_wr)
                                    begin
                                        reg_we    = 1'b1;
                                        reg_wdata = {reg_rdata[31:24], wdata_reg,
                                                     reg_rdata[15:0]};
                                    end
                                    else
                                    begin
                                        read_data_next = reg_rdata[23:16];
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end

                        MODE_CRTC_RD, MODE_CRTC_WR:
                        begin
                            if (offset_reg <= CRTC_OFF_LAST_BYTE)
                            begin
                                if (is_wr)
                                begin
                                    crtc_byte_next[offset_reg] = wdata_reg;
                                end
                                else
                                begin
                                    read_data_next = crtc_byte_reg[offset_reg];
                                end
                            end
                            else if (offset_reg == CRTC_OFF_INDEX)
                            begin
                                if (is_wr)
                                begin
                                    crtc_index_next = wdata_reg;
                                    crtc_q_next     = q_calc;
                                    crtc_high_next  = 1'b0;
                                end
                                else
                                begin
                                    read_data_next = crtc_index_reg;
                                end
                            end
                            else
                            begin
                                if (!is_wr)
                                begin
                                    read_data_next = crtc_high_reg ? tv_old[15:8] : tv_old[7:0];
                                end
                                else
                                begin
                                    if (crtc_high_reg)
                                    begin
                                        tv_new          = (tv_old & LOW_MASK) | {wdata_reg, 8'h00};
                                        crtc_index_next = crtc_index_reg + 8'd1;
                                        crtc_q_next     = q_calc;
                                        crtc_high_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        tv_new         = (tv_old & HIGH_MASK) | {8'h00, wdata_reg};
                                        crtc_high_next = 1'b1;
                                    end
                                    reg_we    = 1'b1;
                                    reg_wdata = {reg_rdata[31:16], tv_new};
                                    if (crtc_ridx == RIDX_W'(TIMING_HACT_START))
                                    begin
                                        shadow_next.hact_start = tv_new;
                                    end
                                    if (crtc_ridx == RIDX_W'(TIMING_HTOTAL))
                                    begin
                                        shadow_next.htotal = tv_new;
                                    end
                                    if (crtc_ridx == RIDX_W'(TIMING_VACT_START))
                                    begin
                                        shadow_next.vact_start = tv_new;
                                    end
                                    if (crtc_ridx == RIDX_W'(TIMING_VTOTAL))
                                    begin
                                        shadow_next.vtotal = tv_new;
                                    end
                                end
                            end
                        end

                        MODE_PIXEL:
                        begin
                            red_next   = pal_rdata[23:16];
                            green_next = pal_rdata[15:8];
                            blue_next  = pal_rdata[7:0];
                        end

                        default:
                        begin
                        end
                    endcase

                    width_next  = geom.width;
                    height_next = geom.height;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            dac_index_reg  <= '0;
            dac_q_reg      <= '0;
            crtc_index_reg <= '0;
            crtc_q_reg     <= '0;
            crtc_high_reg  <= 1'b0;
            pal_row_reg    <= '0;
            pal_lane_reg   <= LANE_RED;
            for (int i = 0; i < CRTC_BYTE_REGS; i++)
            begin
                crtc_byte_reg[i] <= '0;
            end
            shadow_reg     <= '0;
            out_valid_reg  <= 1'b0;
            read_data_reg  <= '0;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            dac_index_reg  <= dac_index_next;
            dac_q_reg      <= dac_q_next;
            crtc_index_reg <= crtc_index_next;
            crtc_q_reg     <= crtc_q_next;
            crtc_high_reg  <= crtc_high_next;
            pal_row_reg    <= pal_row_next;
            pal_lane_reg   <= pal_lane_next;
            crtc_byte_reg  <= crtc_byte_next;
            shadow_reg     <= shadow_next;
            out_valid_reg  <= out_valid_next;
            read_data_reg  <= read_data_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        offset_reg    <= offset_next;
        wdata_reg     <= wdata_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign active_width  = width_reg;
    assign active_height = height_reg;

endmodule

/* bench/video_regs_checker.sv */
`timescale 1ns / 1ps
// Checker for the video DAC / CRTC register block: predicts each word and compares outputs.
module video_regs_checker #(
    parameter logic [vdcrb_pkg::CFG_ADDR_W-1:0] ID_ADDR    = '0,
    parameter int                               FILE_DEPTH = vdcrb_pkg::REG_FILE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [vdcrb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vdcrb_pkg::CFG_DATA_W-1:0]  pwdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [2:0]                        mode,
    input  logic [2:0]                        offset,
    input  logic [7:0]                        write_data,
    input  logic [7:0]                        pixel_index,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [7:0]                        read_data,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    input  logic [11:0]                       active_width,
    input  logic [11:0]                       active_height,
    output int                                mismatches,
    output int                                pending
);
    import vdcrb_pkg::*;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] width;
        logic [11:0] height;
    } video_word_t;

    logic [7:0]  id_value;
    logic [7:0]  pal_mem [PALETTE_BYTES];
    logic [9:0]  pal_ptr;
    logic [7:0]  dac_idx;
    logic [7:0]  file_a [FILE_DEPTH];
    logic [7:0]  file_b [FILE_DEPTH];
    logic [7:0]  crtc_bytes [CRTC_BYTE_REGS];
    logic [7:0]  crtc_ptr;
    logic        crtc_hi;
    logic [15:0] timing [FILE_DEPTH];

    video_word_t expected_words [$];
    video_word_t want;
    video_word_t next_word;

    task automatic flag_mismatch(input string what, input logic [11:0] got,
                                 input logic [11:0] exp_val);
        mismatches++;
        $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, exp_val);
    endtask

    // Applies one word to the shadow state and returns the word it should produce.
    task automatic predict_word(input logic [2:0] m, input logic [2:0] o,
                                input logic [7:0] d, input logic [7:0] p,
                                output video_word_t w);
        int          ri;
        int          ti;
        int          wd;
        int          ht;
        logic        wr;
        logic [15:0] cur;
        w  = '0;
        ri = int'(dac_idx) % FILE_DEPTH;
        ti = int'(crtc_ptr) % FILE_DEPTH;
        wr = (m == MODE_DAC_WR) || (m == MODE_CRTC_WR);
        case (m)
            MODE_DAC_RD, MODE_DAC_WR:
            begin
                case (o)
                    DAC_OFF_INDEX:
                    begin
                        if (wr)
                        begin
                            dac_idx = d;
                            pal_ptr = 10'((int'(d) * PAL_LANES) % PALETTE_BYTES);
                        end
                        else
                        begin
                            w.read_data = dac_idx;
                        end
                    end
                    DAC_OFF_DATA:
                    begin
                        if (wr)
                            pal_mem[pal_ptr] = d;
                        else
                            w.read_data = pal_mem[pal_ptr];
                        pal_ptr = 10'((int'(pal_ptr) + 1) % PALETTE_BYTES);
                    end
                    DAC_OFF_ID:
                    begin
                        if (!wr)
                            w.read_data = id_value;
                    end
                    DAC_OFF_FILE_A:
                    begin
                        if (wr)
                            file_a[ri] = d;
                        else
                            w.read_data = file_a[ri];
                    end
                    DAC_OFF_FILE_B:
                    begin
                        if (wr)
                            file_b[ri] = d;
                        else
                            w.read_data = file_b[ri];
                    end
                    default: ;
                endcase
            end
            MODE_CRTC_RD, MODE_CRTC_WR:
            begin
                if (o <= CRTC_OFF_LAST_BYTE)
                begin
                    if (wr)
                        crtc_bytes[o] = d;
                    else
                        w.read_data = crtc_bytes[o];
                end
                else if (o == CRTC_OFF_INDEX)
                begin
                    if (wr)
                    begin
                        crtc_ptr = d;
                        crtc_hi  = 1'b0;
                    end
                    else
                    begin
                        w.read_data = crtc_ptr;
                    end
                end
                else
                begin
                    cur = timing[ti];
                    if (!wr)
                    begin
                        w.read_data = crtc_hi ? cur[15:8] : cur[7:0];
                    end
                    else if (crtc_hi)
                    begin
                        timing[ti] = (cur & LOW_MASK) | {d, 8'h00};
                        crtc_ptr   = crtc_ptr + 8'd1;
                        crtc_hi    = 1'b0;
                    end
                    else
                    begin
                        timing[ti] = (cur & HIGH_MASK) | {8'h00, d};
                        crtc_hi    = 1'b1;
                    end
                end
            end
            MODE_PIXEL:
            begin
                w.red   = pal_mem[int'(p) * PAL_LANES + int'(LANE_RED)];
                w.green = pal_mem[int'(p) * PAL_LANES + int'(LANE_GREEN)];
                w.blue  = pal_mem[int'(p) * PAL_LANES + int'(LANE_BLUE)];
            end
            default: ;
        endcase
        // size comes from the state after this word's access
        wd = (int'(timing[TIMING_HTOTAL]) - int'(timing[TIMING_HACT_START])) * 2 + 2;
        ht = int'(timing[TIMING_VTOTAL]) - int'(timing[TIMING_VACT_START]) + 1;
        if (wd < MIN_SIZE || wd > MAX_SIZE || ht < MIN_SIZE || ht > MAX_SIZE)
        begin
            wd = FALLBACK_W;
            ht = FALLBACK_H;
        end
        w.width  = 12'(wd);
        w.height = 12'(ht);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_value = DEVICE_ID_RESET;
            pal_ptr  = '0;
            dac_idx  = '0;
            crtc_ptr = '0;
            crtc_hi  = 1'b0;
            for (int i = 0; i < PALETTE_BYTES; i++)
                pal_mem[i] = '0;
            for (int i = 0; i < FILE_DEPTH; i++)
            begin
                file_a[i] = '0;
                file_b[i] = '0;
                timing[i] = '0;
            end
            for (int i = 0; i < CRTC_BYTE_REGS; i++)
                crtc_bytes[i] = '0;
            expected_words.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ID_ADDR)
                id_value = pwdata[7:0];
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    flag_mismatch("result word with nothing expected", read_data, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (read_data !== want.read_data)
                        flag_mismatch("read_data", read_data, want.read_data);
                    if (red !== want.red)
                        flag_mismatch("red", red, want.red);
                    if (green !== want.green)
                        flag_mismatch("green", green, want.green);
                    if (blue !== want.blue)
                        flag_mismatch("blue", blue, want.blue);
                    if (active_width !== want.width)
                        flag_mismatch("active_width", active_width, want.width);
                    if (active_height !== want.height)
                        flag_mismatch("active_height", active_height, want.height);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_word(mode, offset, write_data, pixel_index, next_word);
                expected_words.push_back(next_word);
            end
            pending = expected_words.size();
        end
    end

endmodule

/* bench/video_dac_crtc_register_block_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the video DAC / CRTC register block: stimulus, ID register writes, verdict.
module video_dac_crtc_register_block_unit_tb;
    import vdcrb_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] DEVICE_ID_ADDR = '0;
    localparam logic [2:0] DAC_OFF_SPARE_A     = 3'd3;
    localparam logic [2:0] DAC_OFF_SPARE_B     = 3'd4;
    localparam logic [2:0] DAC_OFF_SPARE_C     = 3'd7;
    localparam logic [2:0] MODE_SPARE_FIRST    = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST     = 3'd7;
    localparam int         RANDOM_WORDS        = 1650;
    localparam int         CONFIG_PHASES       = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            mode;
    logic [2:0]            offset;
    logic [7:0]            write_data;
    logic [7:0]            pixel_index;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            read_data;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [11:0]           active_width;
    logic [11:0]           active_height;

    int mismatches;
    int pending;
    int words_sent;
    int burst_left;
    int stall_left;
    int stall_style;

    video_dac_crtc_register_block_unit dut (.*);

    video_regs_checker #(.ID_ADDR(DEVICE_ID_ADDR)) regs_check (.*);

    always #1 clk = ~clk;

    // receiver: changes its stall style whenever its random countdown runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
        end
        else
        begin
            stall_left--;
        end
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (stall_left % 3 == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_word(input logic [2:0] m, input logic [2:0] o,
                             input logic [7:0] d, input logic [7:0] p);
        int gap;
        in_valid    <= 1'b1;
        mode        <= m;
        offset      <= o;
        write_data  <= d;
        pixel_index <= p;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 7);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CFG_ADDR_W-1:0] a, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= CFG_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // index write, then low/high of two consecutive timing registers
    task automatic write_timing_pair(input int first, input logic [15:0] a,
                                     input logic [15:0] b);
        send_word(MODE_CRTC_WR, CRTC_OFF_INDEX, 8'(first), 8'($urandom));
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, a[7:0], 8'($urandom));
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, a[15:8], 8'($urandom));
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, b[7:0], 8'($urandom));
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, b[15:8], 8'($urandom));
    endtask

    initial
    begin
        int          id_setting;
        int          phase_end;
        int          directed_words;
        int          pick;
        int          n;
        int          wd;
        int          hd;
        logic [7:0]  idx;
        logic [15:0] hact;
        logic [15:0] htotal;
        logic [15:0] vact;
        logic [15:0] vtotal;
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        mode        = '0;
        offset      = '0;
        write_data  = '0;
        pixel_index = '0;
        out_ready   = 1'b0;
        words_sent  = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_style = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(MODE_DAC_RD, DAC_OFF_ID, 8'h00, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_ID, 8'hff, 8'hff);
        send_word(MODE_DAC_WR, DAC_OFF_INDEX, 8'hff, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_DATA, 8'hff, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_DATA, 8'h80, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_DATA, 8'h01, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_DATA, 8'ha5, 8'h00);
        send_word(MODE_PIXEL, CRTC_OFF_DATA, 8'h00, 8'hff);
        send_word(MODE_PIXEL, CRTC_OFF_DATA, 8'hff, 8'h00);
        send_word(MODE_DAC_RD, DAC_OFF_INDEX, 8'h00, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_FILE_A, 8'hff, 8'h00);
        send_word(MODE_DAC_RD, DAC_OFF_FILE_A, 8'h00, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_FILE_B, 8'h5a, 8'h00);
        send_word(MODE_DAC_WR, DAC_OFF_SPARE_A, 8'hff, 8'h00);
        send_word(MODE_DAC_RD, DAC_OFF_SPARE_B, 8'h00, 8'h00);
        send_word(MODE_DAC_RD, DAC_OFF_SPARE_C, 8'h00, 8'h00);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_word(3'(m), DAC_OFF_DATA, 8'hff, 8'hff);
        send_word(MODE_CRTC_WR, CRTC_OFF_LAST_BYTE, 8'hff, 8'h00);
        send_word(MODE_CRTC_RD, CRTC_OFF_LAST_BYTE, 8'h00, 8'h00);
        send_word(MODE_CRTC_WR, CRTC_OFF_INDEX, 8'hff, 8'h00);
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, 8'hff, 8'h00);
        send_word(MODE_CRTC_RD, CRTC_OFF_DATA, 8'h00, 8'h00);
        send_word(MODE_CRTC_WR, CRTC_OFF_INDEX, 8'hff, 8'h00);
        send_word(MODE_CRTC_RD, CRTC_OFF_DATA, 8'h00, 8'h00);
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, 8'h12, 8'h00);
        send_word(MODE_CRTC_WR, CRTC_OFF_DATA, 8'hff, 8'h00);
        send_word(MODE_CRTC_RD, CRTC_OFF_INDEX, 8'h00, 8'h00);
        directed_words = words_sent;

        for (int ph = 0; ph < CONFIG_PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       id_setting = 8'h00;
                1:       id_setting = 8'hff;
                default: id_setting = $urandom_range(0, 255);
            endcase
            apb_write(DEVICE_ID_ADDR, 8'(id_setting));
            phase_end = directed_words + (ph + 1) * RANDOM_WORDS / CONFIG_PHASES;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    // active size programming, edges of the legal range included
                    case ($urandom_range(0, 5))
                        0:       wd = 30;
                        1:       wd = 31;
                        2:       wd = 1023;
                        3:       wd = 1024;
                        default: wd = $urandom_range(31, 1023);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       hd = 62;
                        1:       hd = 63;
                        2:       hd = 2047;
                        3:       hd = 2048;
                        default: hd = $urandom_range(63, 2047);
                    endcase
                    if ($urandom_range(0, 5) == 0)
                    begin
                        hact   = 16'($urandom);
                        htotal = 16'($urandom);
                        vact   = 16'($urandom);
                        vtotal = 16'($urandom);
                    end
                    else
                    begin
                        hact   = 16'($urandom_range(0, 16'hffff - wd));
                        htotal = hact + 16'(wd);
                        vact   = 16'($urandom_range(0, 16'hffff - hd));
                        vtotal = vact + 16'(hd);
                    end
                    write_timing_pair(TIMING_HACT_START, hact, htotal);
                    write_timing_pair(TIMING_VACT_START, vact, vtotal);
                end
                else if (pick < 50)
                begin
                    // palette load, then read back or look up
                    idx = 8'($urandom);
                    n   = $urandom_range(1, 9);
                    send_word(MODE_DAC_WR, DAC_OFF_INDEX, idx, 8'($urandom));
                    repeat (n) send_word(MODE_DAC_WR, DAC_OFF_DATA, 8'($urandom), 8'($urandom));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_word(MODE_DAC_WR, DAC_OFF_INDEX, idx, 8'($urandom));
                        repeat (n)
                            send_word(MODE_DAC_RD, DAC_OFF_DATA, 8'($urandom), 8'($urandom));
                    end
                    else
                    begin
                        for (int k = 0; k < (n + 2) / 3; k++)
                            send_word(MODE_PIXEL, 3'($urandom), 8'($urandom), idx + 8'(k));
                    end
                end
                else if (pick < 65)
                begin
                    repeat ($urandom_range(1, 8))
                        send_word(MODE_PIXEL, 3'($urandom), 8'($urandom), 8'($urandom));
                end
                else if (pick < 80)
                begin
                    repeat ($urandom_range(2, 8))
                        send_word(3'($urandom_range(MODE_DAC_RD, MODE_CRTC_WR)), 3'($urandom),
                                  8'($urandom), 8'($urandom));
                end
                else if (pick < 90)
                begin
                    send_word(MODE_CRTC_WR, CRTC_OFF_INDEX, 8'($urandom), 8'($urandom));
                    repeat ($urandom_range(1, 6))
                        send_word($urandom_range(0, 1) ? MODE_CRTC_WR : MODE_CRTC_RD,
                                  CRTC_OFF_DATA, 8'($urandom), 8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* video_dac_crtc_register_block_unit.f */
sv/vdcrb_pkg.sv
sv/vdcrb_ram.sv
sv/vdcrb_apb.sv
sv/vdcrb_geom.sv
sv/video_dac_crtc_register_block_unit.sv
bench/video_regs_checker.sv
bench/video_dac_crtc_register_block_unit_tb.sv
